// File: sv/mip_chain_surface_locator_defines.svh
// Assertion macros shared by the surface locator RTL.
// Included by the top level; depends on nothing else.
`ifndef MIP_CHAIN_SURFACE_LOCATOR_DEFINES_SVH
`define MIP_CHAIN_SURFACE_LOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCSL_ASSERT_SAME(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("mcsl: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCSL_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("mcsl: next-cycle check failed");

`endif

// File: sv/mcsl_pkg.sv
// Types and constants of the mip chain surface locator.
// Used by the channel interfaces and by every module of the block.
`timescale 1ns / 1ps

package mcsl_pkg;

    localparam int DIM_W      = 15;
    localparam int LVL_W      = 4;
    localparam int FACE_W     = 3;
    localparam int SLICE_W    = 11;
    localparam int DEPTH_W    = 12;
    localparam int BLK_W      = 4;
    localparam int BYTES_W    = 5;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 3;

    localparam int XY_W       = 2 * DIM_W;
    localparam int SIZE_W     = XY_W + BYTES_W;
    localparam int OUT_SIZE_W = 33;
    localparam int MUL_A_W    = SIZE_W;
    localparam int MUL_B_W    = DIM_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 56;

    localparam int DIV_W         = DIM_W + 1;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_STEPS     = DIV_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_LEVEL_COUNT  = 3'd2,
        REG_FACE_COUNT   = 3'd3,
        REG_DEPTH_COUNT  = 3'd4,
        REG_BLOCK_WIDTH  = 3'd5,
        REG_BLOCK_HEIGHT = 3'd6,
        REG_BLOCK_BYTES  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [LVL_W-1:0]   level_count;
        logic [FACE_W-1:0]  face_count;
        logic [DEPTH_W-1:0] depth_count;
        logic [BLK_W-1:0]   block_width;
        logic [BLK_W-1:0]   block_height;
        logic [BYTES_W-1:0] block_bytes;
    } cfg_t;

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_add;
    } arith_ctrl_t;

    typedef enum logic [2:0] {
        MS_FACES = 3'd0,
        MS_XY    = 3'd1,
        MS_BYTES = 3'd2,
        MS_LEVEL = 3'd3,
        MS_FACE  = 3'd4,
        MS_SURF  = 3'd5
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_CHECK = 4'd1,
        ST_FD    = 4'd2,
        ST_XW    = 4'd3,
        ST_YW    = 4'd4,
        ST_MB    = 4'd5,
        ST_SZ    = 4'd6,
        ST_ACC   = 4'd7,
        ST_K     = 4'd8,
        ST_KM    = 4'd9,
        ST_FIN   = 4'd10,
        ST_OUT   = 4'd11
    } state_t;

endpackage

// File: sv/mcsl_chan_if.sv
// Request and result channels of the surface locator, valid/ready handshake.
// Depends on mcsl_pkg for the field widths.
`timescale 1ns / 1ps

interface mcsl_req_if;
    logic                            valid;
    logic                            ready;
    logic [mcsl_pkg::LVL_W-1:0]      mip_level;
    logic [mcsl_pkg::SLICE_W-1:0]    slice_index;
    logic [mcsl_pkg::FACE_W-1:0]     face_index;

    modport source (output valid, output mip_level, output slice_index, output face_index,
                    input ready);
    modport sink (input valid, input mip_level, input slice_index, input face_index,
                  output ready);
endinterface

interface mcsl_rsp_if #(
    parameter int OFFSET_BITS = 48
);
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic [OFFSET_BITS-1:0]            byte_offset;
    logic [mcsl_pkg::OUT_SIZE_W-1:0]   byte_size;

    modport source (output valid, output found, output byte_offset, output byte_size,
                    input ready);
    modport sink (input valid, input found, input byte_offset, input byte_size,
                  output ready);
endinterface

// File: sv/mcsl_cfg_regs.sv
// Configuration register file of the surface locator, write-only.
// Depends on mcsl_pkg for the register index codes and the cfg_t layout.
`timescale 1ns / 1ps

module mcsl_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  mcsl_pkg::cfg_index_t                cfg_index,
    input  logic [mcsl_pkg::CFG_DATA_W-1:0]     cfg_data,
    output mcsl_pkg::cfg_t                      cfg
);
    import mcsl_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= DIM_W'(1);
            cfg_reg.image_height <= DIM_W'(1);
            cfg_reg.level_count  <= LVL_W'(1);
            cfg_reg.face_count   <= FACE_W'(1);
            cfg_reg.depth_count  <= DEPTH_W'(1);
            cfg_reg.block_width  <= BLK_W'(1);
            cfg_reg.block_height <= BLK_W'(1);
            cfg_reg.block_bytes  <= BYTES_W'(4);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[DIM_W-1:0];
                REG_LEVEL_COUNT:  cfg_reg.level_count  <= cfg_data[LVL_W-1:0];
                REG_FACE_COUNT:   cfg_reg.face_count   <= cfg_data[FACE_W-1:0];
                REG_DEPTH_COUNT:  cfg_reg.depth_count  <= cfg_data[DEPTH_W-1:0];
                REG_BLOCK_WIDTH:  cfg_reg.block_width  <= cfg_data[BLK_W-1:0];
                REG_BLOCK_HEIGHT: cfg_reg.block_height <= cfg_data[BLK_W-1:0];
                REG_BLOCK_BYTES:  cfg_reg.block_bytes  <= cfg_data[BYTES_W-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/mcsl_div.sv
// Iterative restoring divider, four quotient bits per cycle, narrow divisor.
// Depends on mcsl_pkg for the dividend width and the step count.
`timescale 1ns / 1ps

module mcsl_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [mcsl_pkg::DIV_W-1:0]        num,
    input  logic [mcsl_pkg::BLK_W-1:0]        den,
    output logic                              done,
    output logic [mcsl_pkg::DIV_W-1:0]        quot
);
    import mcsl_pkg::*;

    logic [DIV_W-1:0]         work_reg;
    logic [DIV_W-1:0]         work_next;
    logic [BLK_W-1:0]         rem_reg;
    logic [BLK_W-1:0]         rem_next;
    logic [BLK_W-1:0]         den_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [BLK_W:0]           trial;
    logic [BLK_W-1:0]         part;
    logic [DIV_STEP_BITS-1:0] digit;

    // Each busy cycle shifts the top four dividend bits through the remainder and
    // shifts the resulting quotient bits into the bottom of the work register.
    always_comb
    begin
        part  = rem_reg;
        digit = '0;
        trial = '0;
        for (int j = 0; j < DIV_STEP_BITS; j++)
        begin
            trial = {part, work_reg[DIV_W-1-j]};
            if (trial >= {1'b0, den_reg})
            begin
                trial = trial - {1'b0, den_reg};
                digit[DIV_STEP_BITS-1-j] = 1'b1;
            end
            part = trial[BLK_W-1:0];
        end
        rem_next  = part;
        work_next = {work_reg[DIV_W-DIV_STEP_BITS-1:0], digit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num;
            den_reg  <= den;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

// File: sv/mcsl_arith.sv
// Shared multiplier with a registered product and the offset accumulator.
// Depends on mcsl_pkg for the operand widths and the control struct.
`timescale 1ns / 1ps

module mcsl_arith (
    input  logic                              clk,
    input  mcsl_pkg::arith_ctrl_t             ctrl,
    input  logic [mcsl_pkg::MUL_A_W-1:0]      op_a,
    input  logic [mcsl_pkg::MUL_B_W-1:0]      op_b,
    output logic [mcsl_pkg::PROD_W-1:0]       prod,
    output logic [mcsl_pkg::ACC_W-1:0]        acc
);
    import mcsl_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// File: sv/mip_chain_surface_locator.sv
// Each request names a mip level, a face and a depth slice and gets one result: whether that
// surface exists, its byte offset from the start of the pixel data and its byte size. A hit
// on level L walks the levels 0 to L first, a miss goes straight to the output, and the block
// then returns to idle for the next request. The time goes to one shared 35x15 multiplier and
// a divider that retires four quotient bits per cycle, which every level visits twice, once
// per dimension. Byte size saturates at 2^33-1 and byte offset at 2^OFFSET_BITS-1. A finished
// result waits in an output register while the next request is taken. The user must write
// configuration only while no request is in flight; the block itself does not enforce it.
`timescale 1ns / 1ps
`include "mip_chain_surface_locator_defines.svh"

module mip_chain_surface_locator #(
    parameter int OFFSET_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  mcsl_pkg::cfg_index_t              cfg_index,
    input  logic [mcsl_pkg::CFG_DATA_W-1:0]   cfg_data,
    mcsl_req_if.sink                          req,
    mcsl_rsp_if.source                        rsp
);
    import mcsl_pkg::*;

    cfg_t                  cfg;
    state_t                state_reg;
    state_t                state_next;

    logic [LVL_W-1:0]      lvl_reg;
    logic [SLICE_W-1:0]    slice_reg;
    logic [FACE_W-1:0]     face_reg;
    logic [LVL_W-1:0]      cur_reg;
    logic [DIM_W-1:0]      bx_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [DIM_W-1:0]      fd_reg;
    logic [DIM_W-1:0]      k_reg;
    logic                  found_reg;

    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [OFFSET_BITS-1:0] out_offset_reg;
    logic [OUT_SIZE_W-1:0] out_size_reg;

    logic                  req_ready;
    logic                  miss;
    logic                  at_target;
    logic                  out_free;
    logic                  out_load;

    logic                  div_start;
    logic                  div_dim_y;
    logic                  div_next_lvl;
    logic [LVL_W-1:0]      div_lvl;
    logic [DIM_W-1:0]      div_base;
    logic [DIM_W-1:0]      div_shift;
    logic [DIM_W-1:0]      div_dim;
    logic [BLK_W-1:0]      div_blk;
    logic [DIV_W-1:0]      div_num;
    logic                  div_done;
    logic [DIV_W-1:0]      div_q;

    arith_ctrl_t           arith_ctrl;
    mul_sel_t              mul_sel;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [PROD_W-1:0]     prod;
    logic [ACC_W-1:0]      acc;

    logic [OFFSET_BITS-1:0] off_sat;
    logic [OUT_SIZE_W-1:0] size_sat;

    mcsl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mcsl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_blk),
        .done  (div_done),
        .quot  (div_q)
    );

    mcsl_arith u_arith (
        .clk  (clk),
        .ctrl (arith_ctrl),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod),
        .acc  (acc)
    );

    assign miss = (lvl_reg >= cfg.level_count) || (face_reg >= cfg.face_count)
                  || (DEPTH_W'(slice_reg) >= cfg.depth_count);
    assign at_target = (cur_reg == lvl_reg);
    assign out_free  = !out_valid_reg || rsp.ready;

    // Level dimension, floored at one pixel, plus block size minus one for the ceiling.
    always_comb
    begin
        div_lvl   = div_next_lvl ? (cur_reg + LVL_W'(1)) : cur_reg;
        div_base  = div_dim_y ? cfg.image_height : cfg.image_width;
        div_shift = div_base >> div_lvl;
        div_dim   = (div_shift == '0) ? DIM_W'(1) : div_shift;
        if (div_dim_y)
        begin
            div_blk = (cfg.block_height == '0) ? BLK_W'(1) : cfg.block_height;
        end
        else
        begin
            div_blk = (cfg.block_width == '0) ? BLK_W'(1) : cfg.block_width;
        end
        div_num = DIV_W'(div_dim) + DIV_W'(div_blk) - DIV_W'(1);
    end

    always_comb
    begin
        unique case (mul_sel)
            MS_FACES:
            begin
                mul_a = MUL_A_W'(cfg.face_count);
                mul_b = MUL_B_W'(cfg.depth_count);
            end
            MS_XY:
            begin
                mul_a = MUL_A_W'(bx_reg);
                mul_b = div_q[DIM_W-1:0];
            end
            MS_BYTES:
            begin
                mul_a = MUL_A_W'(prod[XY_W-1:0]);
                mul_b = MUL_B_W'(cfg.block_bytes);
            end
            MS_LEVEL:
            begin
                mul_a = prod[SIZE_W-1:0];
                mul_b = fd_reg;
            end
            MS_FACE:
            begin
                mul_a = MUL_A_W'(face_reg);
                mul_b = MUL_B_W'(cfg.depth_count);
            end
            MS_SURF:
            begin
                mul_a = size_reg;
                mul_b = k_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (req.valid) state_next = ST_CHECK;
            ST_CHECK: state_next = miss ? ST_OUT : ST_FD;
            ST_FD:    state_next = ST_XW;
            ST_XW:    if (div_done) state_next = ST_YW;
            ST_YW:    if (div_done) state_next = ST_MB;
            ST_MB:    state_next = ST_SZ;
            ST_SZ:    state_next = at_target ? ST_K : ST_ACC;
            ST_ACC:   state_next = ST_XW;
            ST_K:     state_next = ST_KM;
            ST_KM:    state_next = ST_FIN;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready    = 1'b0;
        div_start    = 1'b0;
        div_dim_y    = 1'b0;
        div_next_lvl = 1'b0;
        arith_ctrl   = '0;
        mul_sel      = MS_FACES;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_CHECK:
            begin
                arith_ctrl.acc_clr = 1'b1;
                arith_ctrl.mul_en  = 1'b1;
                mul_sel            = MS_FACES;
            end
            ST_FD:
            begin
                div_start = 1'b1;
            end
            ST_XW:
            begin
                div_start = div_done;
                div_dim_y = 1'b1;
            end
            ST_YW:
            begin
                arith_ctrl.mul_en = div_done;
                mul_sel           = MS_XY;
            end
            ST_MB:
            begin
                arith_ctrl.mul_en = 1'b1;
                mul_sel           = MS_BYTES;
            end
            ST_SZ:
            begin
                arith_ctrl.mul_en = 1'b1;
                mul_sel           = at_target ? MS_FACE : MS_LEVEL;
            end
            ST_ACC:
            begin
                arith_ctrl.acc_add = 1'b1;
                div_start          = 1'b1;
                div_next_lvl       = 1'b1;
            end
            ST_K:
            begin
            end
            ST_KM:
            begin
                arith_ctrl.mul_en = 1'b1;
                mul_sel           = MS_SURF;
            end
            ST_FIN:
            begin
                arith_ctrl.acc_add = 1'b1;
            end
            ST_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req_ready)
        begin
            lvl_reg   <= req.mip_level;
            slice_reg <= req.slice_index;
            face_reg  <= req.face_index;
        end
        if (state_reg == ST_CHECK)
        begin
            found_reg <= !miss;
            cur_reg   <= '0;
        end
        if (state_reg == ST_FD)
        begin
            fd_reg <= prod[DIM_W-1:0];
        end
        if (state_reg == ST_XW && div_done)
        begin
            bx_reg <= div_q[DIM_W-1:0];
        end
        if (state_reg == ST_SZ)
        begin
            size_reg <= prod[SIZE_W-1:0];
        end
        if (state_reg == ST_ACC)
        begin
            cur_reg <= cur_reg + LVL_W'(1);
        end
        if (state_reg == ST_K)
        begin
            k_reg <= prod[DIM_W-1:0] + DIM_W'(slice_reg);
        end
    end

    generate
        if (OFFSET_BITS >= ACC_W)
        begin : g_off_wide
            assign off_sat = OFFSET_BITS'(acc);
        end
        else
        begin : g_off_sat
            assign off_sat = (|acc[ACC_W-1:OFFSET_BITS]) ? '1 : acc[OFFSET_BITS-1:0];
        end
    endgenerate

    assign size_sat = (|size_reg[SIZE_W-1:OUT_SIZE_W]) ? '1 : size_reg[OUT_SIZE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg  <= found_reg;
            out_offset_reg <= found_reg ? off_sat : '0;
            out_size_reg   <= found_reg ? size_sat : '0;
        end
    end

    assign req.ready       = req_ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.byte_offset = out_offset_reg;
    assign rsp.byte_size   = out_size_reg;

    `MCSL_ASSERT_NEXT(a_busy_after_request, clk, rst_n, req.valid && req.ready, !req.ready)
    `MCSL_ASSERT_SAME(a_miss_is_zero, clk, rst_n, rsp.valid && !rsp.found, rsp.byte_offset == '0 && rsp.byte_size == '0)
    `MCSL_ASSERT_SAME(a_div_done_awaited, clk, rst_n, div_done, state_reg == ST_XW || state_reg == ST_YW)
    `MCSL_ASSERT_NEXT(a_load_shows_result, clk, rst_n, out_load, rsp.valid && rsp.found == $past(found_reg))

endmodule

// File: sim/mip_chain_surface_locator_tb.sv
// Self-checking testbench of the mip chain surface locator: directed layouts, an output stall
// and randomized layouts, each result checked against a predictor of the surface layout.
// Depends on mcsl_pkg, the channel interfaces in mcsl_chan_if and the block's top level.
`timescale 1ns / 1ps

module mip_chain_surface_locator_tb;
    import mcsl_pkg::*;

    localparam int OFFSET_BITS = 48;
    localparam logic [63:0] OFFSET_LIMIT = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam logic [63:0] SIZE_LIMIT = (64'd1 << OUT_SIZE_W) - 64'd1;
    localparam int RSP_HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES = 250;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_REQUESTS = 150;

    typedef struct packed {
        logic [LVL_W-1:0]   mip_level;
        logic [SLICE_W-1:0] slice_index;
        logic [FACE_W-1:0]  face_index;
    } surface_req_t;

    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [OUT_SIZE_W-1:0]  byte_size;
    } surface_loc_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    cfg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mcsl_req_if req_if ();
    mcsl_rsp_if #(.OFFSET_BITS(OFFSET_BITS)) rsp_if ();

    mip_chain_surface_locator #(
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    cfg_t shadow_cfg = '{image_width: 1, image_height: 1, level_count: 1, face_count: 1,
                         depth_count: 1, block_width: 1, block_height: 1, block_bytes: 4};
    surface_loc_t expected_locations[$];
    int mismatch_count = 0;
    int burst_left = 1;
    bit rsp_hold_pending = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] level_extent(logic [63:0] base, int lvl, logic [63:0] blk);
        logic [63:0] d;
        logic [63:0] b;
        d = base >> lvl;
        if (d == 64'd0)
            d = 64'd1;
        b = (blk == 64'd0) ? 64'd1 : blk;
        return (d + b - 64'd1) / b;
    endfunction

    function automatic logic [63:0] level_bytes(int lvl);
        return level_extent(64'(shadow_cfg.image_width), lvl, 64'(shadow_cfg.block_width)) *
               level_extent(64'(shadow_cfg.image_height), lvl, 64'(shadow_cfg.block_height)) *
               64'(shadow_cfg.block_bytes);
    endfunction

    function automatic surface_loc_t locate_surface(surface_req_t r);
        surface_loc_t s;
        logic [63:0] off;
        logic [63:0] sz;
        logic [63:0] faces;
        logic [63:0] depth;
        s = '0;
        if (r.mip_level >= shadow_cfg.level_count || r.face_index >= shadow_cfg.face_count ||
            {1'b0, r.slice_index} >= shadow_cfg.depth_count)
            return s;
        faces = 64'(shadow_cfg.face_count);
        depth = 64'(shadow_cfg.depth_count);
        off = 64'd0;
        for (int i = 0; i < int'(r.mip_level); i++)
            off += level_bytes(i) * faces * depth;
        sz = level_bytes(int'(r.mip_level));
        off += (64'(r.face_index) * depth + 64'(r.slice_index)) * sz;
        s.found = 1'b1;
        s.byte_offset = (off > OFFSET_LIMIT) ? OFFSET_LIMIT[OFFSET_BITS-1:0]
                                             : off[OFFSET_BITS-1:0];
        s.byte_size = (sz > SIZE_LIMIT) ? SIZE_LIMIT[OUT_SIZE_W-1:0] : sz[OUT_SIZE_W-1:0];
        return s;
    endfunction

    function automatic cfg_t texture_layout(int w, int h, int levels, int faces, int depth,
                                            int bw, int bh, int bytes);
        cfg_t c;
        c.image_width  = DIM_W'(w);
        c.image_height = DIM_W'(h);
        c.level_count  = LVL_W'(levels);
        c.face_count   = FACE_W'(faces);
        c.depth_count  = DEPTH_W'(depth);
        c.block_width  = BLK_W'(bw);
        c.block_height = BLK_W'(bh);
        c.block_bytes  = BYTES_W'(bytes);
        return c;
    endfunction

    function automatic int pick_dimension();
        case ($urandom_range(0, 7))
            0: return 1;
            1: return 16384;
            2, 3: return $urandom_range(1, 64);
            default: return $urandom_range(1, 16384);
        endcase
    endfunction

    function automatic cfg_t pick_texture_layout();
        if ($urandom_range(0, 4) == 0)
            return texture_layout($urandom_range(0, 32767), $urandom_range(0, 32767),
                                  $urandom_range(0, 15), $urandom_range(0, 7),
                                  $urandom_range(0, 4095), $urandom_range(0, 15),
                                  $urandom_range(0, 15), $urandom_range(0, 31));
        return texture_layout(pick_dimension(), pick_dimension(), $urandom_range(1, 15),
                              ($urandom_range(0, 1) == 0) ? 1 : 6,
                              ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2048)
                                                          : $urandom_range(1, 4),
                              $urandom_range(1, 12), $urandom_range(1, 12),
                              $urandom_range(1, 16));
    endfunction

    function automatic surface_req_t pick_request();
        surface_req_t r;
        int max_slice;
        if ($urandom_range(0, 9) < 8 && shadow_cfg.level_count != 0 &&
            shadow_cfg.face_count != 0 && shadow_cfg.depth_count != 0)
        begin
            max_slice = int'(shadow_cfg.depth_count) - 1;
            if (max_slice > 2047)
                max_slice = 2047;
            r.mip_level   = LVL_W'($urandom_range(0, int'(shadow_cfg.level_count) - 1));
            r.face_index  = FACE_W'($urandom_range(0, int'(shadow_cfg.face_count) - 1));
            r.slice_index = SLICE_W'($urandom_range(0, max_slice));
        end
        else
        begin
            r.mip_level   = LVL_W'($urandom_range(0, 15));
            r.face_index  = FACE_W'($urandom_range(0, 7));
            r.slice_index = SLICE_W'($urandom_range(0, 2047));
        end
        return r;
    endfunction

    task automatic offer_request(input logic [LVL_W-1:0] lvl, input logic [SLICE_W-1:0] slice,
                                 input logic [FACE_W-1:0] face);
        surface_req_t r;
        int gap;
        r = '{mip_level: lvl, slice_index: slice, face_index: face};
        req_if.valid       <= 1'b1;
        req_if.mip_level   <= lvl;
        req_if.slice_index <= slice;
        req_if.face_index  <= face;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        expected_locations.push_back(locate_surface(r));
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 10);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic await_all_results();
        req_if.valid <= 1'b0;
        while (expected_locations.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_layout(input cfg_t c);
        await_all_results();
        repeat (4) @(posedge clk);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(c.image_width));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(c.image_height));
        write_reg(REG_LEVEL_COUNT, CFG_DATA_W'(c.level_count));
        write_reg(REG_FACE_COUNT, CFG_DATA_W'(c.face_count));
        write_reg(REG_DEPTH_COUNT, CFG_DATA_W'(c.depth_count));
        write_reg(REG_BLOCK_WIDTH, CFG_DATA_W'(c.block_width));
        write_reg(REG_BLOCK_HEIGHT, CFG_DATA_W'(c.block_height));
        write_reg(REG_BLOCK_BYTES, CFG_DATA_W'(c.block_bytes));
        cfg_we <= 1'b0;
        shadow_cfg = c;
    endtask

    task automatic test_reset_layout();
        offer_request(0, 0, 0);
        offer_request(1, 0, 0);
        offer_request(0, 0, 1);
        offer_request(0, 1, 0);
    endtask

    task automatic test_directed_layouts();
        apply_layout(texture_layout(16384, 600, 15, 1, 1, 4, 4, 16));
        offer_request(0, 0, 0);
        offer_request(14, 0, 0);
        offer_request(15, 2047, 7);
        offer_request(7, 1, 1);
        apply_layout(texture_layout(256, 256, 9, 6, 1, 1, 1, 4));
        offer_request(8, 0, 5);
        offer_request(3, 0, 6);
        offer_request(0, 0, 7);
        apply_layout(texture_layout(1023, 777, 10, 1, 1, 5, 6, 16));
        offer_request(0, 0, 0);
        offer_request(4, 0, 0);
        offer_request(9, 0, 0);
        apply_layout(texture_layout(16, 16, 5, 1, 2048, 1, 1, 4));
        offer_request(4, 2047, 0);
        offer_request(0, 1024, 0);
        apply_layout(texture_layout(64, 64, 0, 1, 1, 1, 1, 4));
        offer_request(0, 0, 0);
        apply_layout(texture_layout(64, 64, 3, 0, 1, 1, 1, 4));
        offer_request(0, 0, 0);
        apply_layout(texture_layout(64, 64, 3, 1, 0, 1, 1, 4));
        offer_request(0, 0, 0);
        apply_layout(texture_layout(32, 32, 6, 7, 3, 1, 1, 2));
        offer_request(5, 2, 6);
        apply_layout(texture_layout(0, 0, 4, 1, 1, 0, 0, 8));
        offer_request(3, 0, 0);
        apply_layout(texture_layout(100, 50, 7, 1, 1, 3, 3, 0));
        offer_request(2, 0, 0);
        apply_layout(texture_layout(32767, 32767, 15, 7, 4095, 1, 1, 31));
        offer_request(0, 0, 0);
        offer_request(1, 0, 0);
        offer_request(14, 2047, 6);
    endtask

    task automatic test_output_stall();
        surface_req_t r;
        apply_layout(texture_layout(128, 64, 4, 6, 8, 4, 4, 8));
        rsp_hold_pending = 1'b1;
        while (rsp_hold_pending)
            @(posedge clk);
        repeat (12)
        begin
            r = pick_request();
            offer_request(r.mip_level, r.slice_index, r.face_index);
        end
        await_all_results();
    endtask

    task automatic test_random_layouts();
        surface_req_t r;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_layout(pick_texture_layout());
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (phase == 3 && n == PHASE_REQUESTS / 2)
                    await_all_results();
                r = pick_request();
                offer_request(r.mip_level, r.slice_index, r.face_index);
            end
        end
        await_all_results();
    endtask

    initial
    begin : rsp_ready_pattern
        int on_len;
        int off_len;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rsp_hold_pending)
            begin
                rsp_if.ready <= 1'b0;
                rsp_hold_pending = 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge clk);
            end
            on_len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 24);
            off_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            rsp_if.ready <= 1'b1;
            repeat (on_len) @(posedge clk);
            if (off_len > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (off_len) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        surface_loc_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_locations.size() == 0)
            begin
                $error("unexpected result: found %0d offset %0d size %0d",
                       rsp_if.found, rsp_if.byte_offset, rsp_if.byte_size);
                mismatch_count++;
            end
            else
            begin
                want = expected_locations.pop_front();
                if (rsp_if.found !== want.found)
                begin
                    $error("found mismatch: expected %0d, got %0d", want.found, rsp_if.found);
                    mismatch_count++;
                end
                if (rsp_if.byte_offset !== want.byte_offset)
                begin
                    $error("byte_offset mismatch: expected %0d, got %0d",
                           want.byte_offset, rsp_if.byte_offset);
                    mismatch_count++;
                end
                if (rsp_if.byte_size !== want.byte_size)
                begin
                    $error("byte_size mismatch: expected %0d, got %0d",
                           want.byte_size, rsp_if.byte_size);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("[mip_chain_surface_locator] ERROR");
        $finish;
    end

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_IMAGE_WIDTH;
        cfg_data           <= '0;
        req_if.valid       <= 1'b0;
        req_if.mip_level   <= '0;
        req_if.slice_index <= '0;
        req_if.face_index  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_layout();
        test_directed_layouts();
        test_output_stall();
        test_random_layouts();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_locations.size() == 0)
            $display("[mip_chain_surface_locator] OK");
        else
            $display("[mip_chain_surface_locator] ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/mcsl_pkg.sv
sv/mcsl_chan_if.sv
sv/mcsl_cfg_regs.sv
sv/mcsl_div.sv
sv/mcsl_arith.sv
sv/mip_chain_surface_locator.sv
sim/mip_chain_surface_locator_tb.sv
